@@ hdl/assert_macros.svh @@
// assertion helpers; every use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/grwc_pkg.sv @@
`default_nettype none
package grwc_pkg;

    // default sizes
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_COUNT_BITS = 32;

    // smallest grid after clamping
    localparam int MIN_ROWS = 3;
    localparam int MIN_COLS = 2;

    // command codes
    localparam logic [1:0] CMD_STEP    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_MOVED     = 3'd0;
    localparam logic [2:0] STAT_WALL      = 3'd1;
    localparam logic [2:0] STAT_FINISHED  = 3'd2;
    localparam logic [2:0] STAT_READ      = 3'd3;
    localparam logic [2:0] STAT_RESTARTED = 3'd4;
    localparam logic [2:0] STAT_BAD_START = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;
    localparam logic [1:0] REG_START_ROW = 2'd2;
    localparam logic [1:0] REG_START_COL = 2'd3;

    // row offset of each of the eight directions
    function automatic logic signed [1:0] row_off(input logic [2:0] dir);
        logic signed [1:0] r;
        case (dir)
            3'd0:    r = -2'sd1;
            3'd1:    r = 2'sd0;
            3'd2:    r = 2'sd1;
            3'd3:    r = 2'sd1;
            3'd4:    r = 2'sd1;
            3'd5:    r = 2'sd0;
            3'd6:    r = -2'sd1;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    // column offset of each of the eight directions
    function automatic logic signed [1:0] col_off(input logic [2:0] dir);
        logic signed [1:0] c;
        case (dir)
            3'd0:    c = 2'sd1;
            3'd1:    c = 2'sd1;
            3'd2:    c = 2'sd1;
            3'd3:    c = 2'sd0;
            3'd4:    c = -2'sd1;
            3'd5:    c = -2'sd1;
            3'd6:    c = -2'sd1;
            default: c = 2'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/grwc_ram.sv @@
`default_nettype none
module grwc_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/grid_random_walk_coverage.sv @@
// Random-walk grid coverage: a walker steps over a grid of visit counters kept in one
// synchronous memory of MAX_ROWS*MAX_COLS entries. For a step or a read, the beat is
// taken and the counter memory read, then, once the output register is free, the
// result is formed and the counter written back; the next beat is taken in the cycle
// after. A valid restart clears the whole counter memory (2048 entries by default) at
// one entry per cycle, then posts its result once the output register is free;
// the same clearing pass runs after reset, and s_tready stays low during it. Config
// writes go through at any time but are meant to happen while the block is idle; the
// grid size and start cell take effect at the next restart. Steps are refused with
// "already finished" until the first valid restart.
`default_nettype none
module grid_random_walk_coverage
    import grwc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[1:0], direction[4:2], query_row[10:5], query_col[15:11]
    input  wire logic [15:0] s_tdata,
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], pos_row[8:3], pos_col[13:9], cell_visits[45:14],
    // moves_made[77:46], remaining[89:78], all_visited[90], zero pad[95:91]
    output logic [95:0]      m_tdata
);

`include "assert_macros.svh"

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ARW    = $clog2(MAX_ROWS + 1);
    localparam int ACW    = $clog2(MAX_COLS + 1);
    localparam int LEFT_W = $clog2(CELLS + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // configuration registers
    logic [6:0] grid_rows_reg;
    logic [5:0] grid_cols_reg;
    logic [5:0] start_row_reg;
    logic [4:0] start_col_reg;

    // walk state
    logic [1:0]            state_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic                  pend_reg;
    logic [ROW_W-1:0]      cur_row_reg;
    logic [COL_W-1:0]      cur_col_reg;
    logic [ARW-1:0]        act_rows_reg;
    logic [ACW-1:0]        act_cols_reg;
    logic [COUNT_BITS-1:0] legal_reg;
    logic [LEFT_W-1:0]     cells_left_reg;
    logic                  finished_reg;
    logic                  m_valid_reg;
    logic [95:0]           m_data_reg;

    // per-item latches
    logic [2:0]            status_reg;
    logic                  move_reg;
    logic                  zero_reg;
    logic [ROW_W-1:0]      new_row_reg;
    logic [COL_W-1:0]      new_col_reg;
    logic [AW-1:0]         wr_addr_reg;

    // memory ports
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;

    // input fields
    logic [1:0] in_cmd;
    logic [2:0] in_dir;
    logic [5:0] in_qrow;
    logic [4:0] in_qcol;

    assign in_cmd  = s_tdata[1:0];
    assign in_dir  = s_tdata[4:2];
    assign in_qrow = s_tdata[10:5];
    assign in_qcol = s_tdata[15:11];

    logic accept;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // clamped grid size and start check for a restart
    logic [ARW-1:0]    nr_clamp;
    logic [ACW-1:0]    nc_clamp;
    logic              start_ok;
    logic [LEFT_W-1:0] cells_new;

    always_comb
    begin
        if (32'(grid_rows_reg) < 32'(MIN_ROWS))
            nr_clamp = ARW'(MIN_ROWS);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            nr_clamp = ARW'(MAX_ROWS);
        else
            nr_clamp = ARW'(grid_rows_reg);
        if (32'(grid_cols_reg) < 32'(MIN_COLS))
            nc_clamp = ACW'(MIN_COLS);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            nc_clamp = ACW'(MAX_COLS);
        else
            nc_clamp = ACW'(grid_cols_reg);
        start_ok  = (32'(start_row_reg) < 32'(nr_clamp)) &&
                    (32'(start_col_reg) < 32'(nc_clamp));
        cells_new = LEFT_W'(nr_clamp) * LEFT_W'(nc_clamp);
    end

    // target cell of a step
    logic [ROW_W+1:0] nr_ext;
    logic [COL_W+1:0] nc_ext;
    logic             step_ok;

    always_comb
    begin
        nr_ext  = {2'b00, cur_row_reg} + (ROW_W + 2)'(row_off(in_dir));
        nc_ext  = {2'b00, cur_col_reg} + (COL_W + 2)'(col_off(in_dir));
        step_ok = !nr_ext[ROW_W+1] && !nc_ext[COL_W+1] &&
                  (nr_ext < (ROW_W + 2)'(act_rows_reg)) &&
                  (nc_ext < (COL_W + 2)'(act_cols_reg));
    end

    // decode of an accepted beat
    logic [2:0]    acc_status;
    logic          acc_move;
    logic          acc_zero;
    logic          acc_restart;
    logic [AW-1:0] acc_addr;
    logic [AW-1:0] cur_addr;

    always_comb
    begin
        cur_addr    = cell_addr(cur_row_reg, cur_col_reg);
        acc_status  = STAT_READ;
        acc_move    = 1'b0;
        acc_zero    = 1'b0;
        acc_restart = 1'b0;
        acc_addr    = cur_addr;
        case (in_cmd)
            CMD_RESTART:
            begin
                acc_status  = start_ok ? STAT_RESTARTED : STAT_BAD_START;
                acc_restart = start_ok;
            end
            CMD_STEP:
            begin
                if (finished_reg)
                    acc_status = STAT_FINISHED;
                else if (step_ok)
                begin
                    acc_status = STAT_MOVED;
                    acc_move   = 1'b1;
                    acc_addr   = cell_addr(ROW_W'(nr_ext), COL_W'(nc_ext));
                end
                else
                    acc_status = STAT_WALL;
            end
            default:
            begin
                acc_status = STAT_READ;
                acc_zero   = !((32'(in_qrow) < 32'(act_rows_reg)) &&
                               (32'(in_qcol) < 32'(act_cols_reg)));
                acc_addr   = cell_addr(ROW_W'(in_qrow), COL_W'(in_qcol));
            end
        endcase
    end

    // counter update of a legal move
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] legal_next;
    logic [LEFT_W-1:0]     left_next;
    logic                  first_entry;

    always_comb
    begin
        cnt_next    = (mem_rdata != CNT_MAX) ? mem_rdata + 1'b1 : mem_rdata;
        legal_next  = (legal_reg != CNT_MAX) ? legal_reg + 1'b1 : legal_reg;
        first_entry = (mem_rdata == '0) && (cells_left_reg != '0);
        left_next   = first_entry ? cells_left_reg - 1'b1 : cells_left_reg;
    end

    // result beat formed in the execute and restart-finish states
    logic [95:0] exec_data;
    logic [95:0] fin_data;
    logic        load_exec;
    logic        load_fin;

    always_comb
    begin
        if (move_reg)
            exec_data = {5'b0, (left_next == '0), 12'(left_next), 32'(legal_next),
                         32'(cnt_next), 5'(new_col_reg), 6'(new_row_reg), status_reg};
        else
            exec_data = {5'b0, (cells_left_reg == '0), 12'(cells_left_reg),
                         32'(legal_reg), (zero_reg ? 32'd0 : 32'(mem_rdata)),
                         5'(cur_col_reg), 6'(cur_row_reg), status_reg};
        fin_data  = {5'b0, (cells_left_reg == '0), 12'(cells_left_reg), 32'(legal_reg),
                     32'd0, 5'(cur_col_reg), 6'(cur_row_reg), STAT_RESTARTED};
        load_exec = (state_reg == S_EXEC) && out_free;
        load_fin  = (state_reg == S_FIN) && pend_reg && out_free;
    end

    // memory access: clearing sweep, or write-back of a move
    always_comb
    begin
        mem_re    = accept;
        mem_raddr = acc_addr;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = load_exec && move_reg;
            mem_waddr = wr_addr_reg;
            mem_wdata = cnt_next;
        end
    end

    grwc_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (COUNT_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= 7'(MIN_ROWS);
            grid_cols_reg <= 6'(MIN_COLS);
            start_row_reg <= '0;
            start_col_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data[5:0];
                REG_START_ROW: start_row_reg <= cfg_data[5:0];
                REG_START_COL: start_col_reg <= cfg_data[4:0];
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // sequencer and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            pend_reg       <= 1'b0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            act_rows_reg   <= ARW'(MIN_ROWS);
            act_cols_reg   <= ACW'(MIN_COLS);
            legal_reg      <= '0;
            cells_left_reg <= '0;
            finished_reg   <= 1'b1;
            move_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == AW'(CELLS - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= pend_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (acc_restart)
                        begin
                            act_rows_reg   <= nr_clamp;
                            act_cols_reg   <= nc_clamp;
                            cur_row_reg    <= ROW_W'(start_row_reg);
                            cur_col_reg    <= COL_W'(start_col_reg);
                            legal_reg      <= '0;
                            cells_left_reg <= cells_new;
                            finished_reg   <= 1'b0;
                            pend_reg       <= 1'b1;
                            state_reg      <= S_CLEAR;
                        end
                        else
                        begin
                            if (in_cmd == CMD_RESTART)
                                finished_reg <= 1'b1;
                            move_reg  <= acc_move;
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        if (move_reg)
                        begin
                            cur_row_reg    <= new_row_reg;
                            cur_col_reg    <= new_col_reg;
                            legal_reg      <= legal_next;
                            cells_left_reg <= left_next;
                            if (first_entry && (left_next == '0))
                                finished_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    if (!pend_reg)
                        state_reg <= S_IDLE;
                    else if (out_free)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // per-item payload latches
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= acc_status;
            zero_reg    <= acc_zero;
            new_row_reg <= ROW_W'(nr_ext);
            new_col_reg <= COL_W'(nc_ext);
            wr_addr_reg <= acc_addr;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_exec || load_fin)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_exec)
            m_data_reg <= exec_data;
        else if (load_fin)
            m_data_reg <= fin_data;
    end

    // terms for the checks
    logic pos_in_grid;
    logic walk_empty;
    logic exec_or_clear;

    assign pos_in_grid   = (32'(cur_row_reg) < 32'(act_rows_reg)) &&
                           (32'(cur_col_reg) < 32'(act_cols_reg));
    assign walk_empty    = (cells_left_reg == '0);
    assign exec_or_clear = (state_reg == S_EXEC) || (state_reg == S_CLEAR);

    // checks
    `ASSERT_ALWAYS(a_pos_in_grid, pos_in_grid, "walker outside the grid")
    `ASSERT_IMPLIES(a_done_when_empty, walk_empty, finished_reg, "walk not finished")
    `ASSERT_NEXT(a_accept_leaves_idle, accept, exec_or_clear, "accepted beat not executed")

endmodule
`default_nettype wire

@@ verif/grid_walk_check.sv @@
module grid_walk_check
    import grwc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // cmd, direction, query_row, query_col
    input  wire logic [15:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // status, pos_row, pos_col, cell_visits, moves_made, remaining, all_visited, pad
    input  wire logic [95:0] m_tdata,
    output int               mismatch_count,
    output int               reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // one result beat, status in the lowest bits
    typedef struct packed {
        logic        all_visited;
        logic [11:0] remaining;
        logic [31:0] moves_made;
        logic [31:0] cell_visits;
        logic [4:0]  pos_col;
        logic [5:0]  pos_row;
        logic [2:0]  status;
    } walk_report_t;

    // mirrored setup registers
    logic [6:0] rows_reg;
    logic [5:0] cols_reg;
    logic [5:0] start_row_reg;
    logic [4:0] start_col_reg;

    // walker state
    int          rows_live;
    int          cols_live;
    logic [5:0]  cur_row;
    logic [4:0]  cur_col;
    logic [31:0] visit_tally [0:2047];
    logic [31:0] legal_total;
    logic [11:0] cells_unvisited;
    logic        walk_done;

    walk_report_t reports_pending [$];

    // count of a cell, zero outside the latched grid
    function automatic logic [31:0] visits_at(input int r, input int c);
        if (r >= rows_live || c >= cols_live)
        begin
            return '0;
        end
        return visit_tally[r * DEF_MAX_COLS + c];
    endfunction

    // apply one command beat to the walker and form its result
    function automatic walk_report_t take_command(input logic [15:0] beat);
        logic [1:0]   cmd;
        logic [2:0]   dir;
        int           q_row;
        int           q_col;
        int           lim_r;
        int           lim_c;
        int           dr;
        int           dc;
        int           nr;
        int           nc;
        int           slot;
        walk_report_t rep;
        cmd   = beat[1:0];
        dir   = beat[4:2];
        q_row = int'(beat[10:5]);
        q_col = int'(beat[15:11]);
        rep   = '0;
        if (cmd == CMD_RESTART)
        begin
            // grid size is clamped when latched
            lim_r = (rows_reg < MIN_ROWS) ? MIN_ROWS :
                    (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
            lim_c = (cols_reg < MIN_COLS) ? MIN_COLS :
                    (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_reg);
            if (start_row_reg >= lim_r || start_col_reg >= lim_c)
            begin
                // start outside grid: refused, walk blocked until a good restart
                walk_done       = 1'b1;
                rep.status      = STAT_BAD_START;
                rep.cell_visits = visits_at(int'(cur_row), int'(cur_col));
            end
            else
            begin
                rows_live = lim_r;
                cols_live = lim_c;
                for (int i = 0; i < DEF_MAX_ROWS * DEF_MAX_COLS; i++)
                begin
                    visit_tally[i] = '0;
                end
                cur_row         = start_row_reg;
                cur_col         = start_col_reg;
                legal_total     = '0;
                cells_unvisited = 12'(lim_r * lim_c);
                walk_done       = 1'b0;
                rep.status      = STAT_RESTARTED;
            end
        end
        else if (cmd == CMD_STEP)
        begin
            if (walk_done)
            begin
                rep.status      = STAT_FINISHED;
                rep.cell_visits = visits_at(int'(cur_row), int'(cur_col));
            end
            else
            begin
                // eight-way offsets
                case (dir)
                    3'd0:    begin dr = -1; dc =  1; end
                    3'd1:    begin dr =  0; dc =  1; end
                    3'd2:    begin dr =  1; dc =  1; end
                    3'd3:    begin dr =  1; dc =  0; end
                    3'd4:    begin dr =  1; dc = -1; end
                    3'd5:    begin dr =  0; dc = -1; end
                    3'd6:    begin dr = -1; dc = -1; end
                    default: begin dr = -1; dc =  0; end
                endcase
                nr = int'(cur_row) + dr;
                nc = int'(cur_col) + dc;
                if (nr < 0 || nc < 0 || nr >= rows_live || nc >= cols_live)
                begin
                    rep.status      = STAT_WALL;
                    rep.cell_visits = visits_at(int'(cur_row), int'(cur_col));
                end
                else
                begin
                    cur_row = 6'(nr);
                    cur_col = 5'(nc);
                    slot    = nr * DEF_MAX_COLS + nc;
                    // first entry of a cell
                    if (visit_tally[slot] == '0 && cells_unvisited != '0)
                    begin
                        cells_unvisited = cells_unvisited - 12'd1;
                        if (cells_unvisited == '0)
                        begin
                            walk_done = 1'b1;
                        end
                    end
                    // saturating counters
                    if (visit_tally[slot] != '1)
                    begin
                        visit_tally[slot] = visit_tally[slot] + 32'd1;
                    end
                    if (legal_total != '1)
                    begin
                        legal_total = legal_total + 32'd1;
                    end
                    rep.status      = STAT_MOVED;
                    rep.cell_visits = visit_tally[slot];
                end
            end
        end
        else
        begin
            // read, and the spare code behaves as a read
            rep.status      = STAT_READ;
            rep.cell_visits = visits_at(q_row, q_col);
        end
        rep.pos_row     = cur_row;
        rep.pos_col     = cur_col;
        rep.moves_made  = legal_total;
        rep.remaining   = cells_unvisited;
        rep.all_visited = (cells_unvisited == '0);
        return rep;
    endfunction

    // compare one field, report the first few
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatch_count < 10)
            begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
            mismatch_count++;
        end
    endfunction

    // watch the ports, predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        walk_report_t seen;
        walk_report_t due;
        if (!rst_n)
        begin
            rows_reg        = 7'd3;
            cols_reg        = 6'd2;
            start_row_reg   = '0;
            start_col_reg   = '0;
            rows_live       = MIN_ROWS;
            cols_live       = MIN_COLS;
            cur_row         = '0;
            cur_col         = '0;
            legal_total     = '0;
            cells_unvisited = '0;
            walk_done       = 1'b1;
            for (int i = 0; i < DEF_MAX_ROWS * DEF_MAX_COLS; i++)
            begin
                visit_tally[i] = '0;
            end
            reports_pending.delete();
            mismatch_count = 0;
            reports_due    = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_ROWS: rows_reg      = cfg_data;
                    REG_GRID_COLS: cols_reg      = cfg_data[5:0];
                    REG_START_ROW: start_row_reg = cfg_data[5:0];
                    REG_START_COL: start_col_reg = cfg_data[4:0];
                    default:       ;
                endcase
            end
            // result beat against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                seen = walk_report_t'(m_tdata[90:0]);
                if (reports_pending.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: result beat with nothing pending: %h", $time, m_tdata);
                    end
                    mismatch_count++;
                end
                else
                begin
                    due = reports_pending.pop_front();
                    check_field("status", 32'(due.status), 32'(seen.status));
                    check_field("pos_row", 32'(due.pos_row), 32'(seen.pos_row));
                    check_field("pos_col", 32'(due.pos_col), 32'(seen.pos_col));
                    check_field("cell_visits", due.cell_visits, seen.cell_visits);
                    check_field("moves_made", due.moves_made, seen.moves_made);
                    check_field("remaining", 32'(due.remaining), 32'(seen.remaining));
                    check_field("all_visited", 32'(due.all_visited), 32'(seen.all_visited));
                end
            end
            // command beat
            if (s_tvalid && s_tready)
            begin
                reports_pending.push_back(take_command(s_tdata));
            end
            reports_due = reports_pending.size();
        end
    end

endmodule

@@ verif/grid_random_walk_coverage_test.sv @@
module grid_random_walk_coverage_test;
    import grwc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         RANDOM_ITEMS  = 1000;
    localparam int         IDLE_LIMIT    = 12000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // cmd[1:0], direction[4:2], query_row[10:5], query_col[15:11]
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // status[2:0], pos_row[8:3], pos_col[13:9], cell_visits[45:14],
    // moves_made[77:46], remaining[89:78], all_visited[90], zero pad[95:91]
    logic [95:0] m_tdata;

    int mismatch_count;
    int reports_due;
    int burst_left;
    int idle_cycles;

    grid_random_walk_coverage uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    grid_walk_check walk_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side back-pressure: short and long stalls, long open stretches
    initial
    begin : result_pacing
        int   hold;
        int   pick;
        logic level;
        m_tready = 1'b0;
        hold     = 0;
        level    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                pick = $urandom_range(0, 99);
                if (level)
                begin
                    level = 1'b0;
                    hold  = (pick < 70) ? $urandom_range(1, 3) :
                            (pick < 92) ? $urandom_range(4, 12) : $urandom_range(20, 60);
                end
                else
                begin
                    level = 1'b1;
                    hold  = (pick < 70) ? $urandom_range(1, 6) :
                            (pick < 90) ? $urandom_range(7, 30) : $urandom_range(100, 300);
                end
            end
            m_tready <= level;
            hold--;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one command beat; called and returns at a falling edge
    task automatic send_command(input logic [1:0] cmd, input logic [2:0] dir,
                                input logic [5:0] q_row, input logic [4:0] q_col);
        int gap;
        int pick;
        s_tdata  <= {q_col, q_row, dir, cmd};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                burst_left = $urandom_range(20, 80);
            else if (pick < 50)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 3);
            else if (pick < 96)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 50);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // step with noise in the unused fields
    task automatic send_step(input logic [2:0] dir);
        send_command(CMD_STEP, dir, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
    endtask

    // drain, then load all four setup registers
    task automatic begin_phase(input logic [6:0] rows, input logic [6:0] cols,
                               input logic [6:0] srow, input logic [6:0] scol);
        s_tvalid <= 1'b0;
        while (reports_due != 0) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data  <= rows;
        @(negedge clk);
        cfg_index <= REG_GRID_COLS;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_index <= REG_START_ROW;
        cfg_data  <= srow;
        @(negedge clk);
        cfg_index <= REG_START_COL;
        cfg_data  <= scol;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int kind;
        int pick;
        int rows;
        int cols;
        int srow;
        int scol;
        int span_r;
        int span_c;
        int n;
        int sent;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_GRID_ROWS;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        burst_left  = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // before any restart: steps refused, reads give zero
        send_step(3'd0);
        send_command(CMD_READ, 3'd7, 6'd0, 5'd0);
        send_command(CMD_SPARE, 3'd0, 6'd63, 5'd31);

        // 3 x 2 walk from the corner, every direction, walls at the top, left and right, to completion
        send_command(CMD_RESTART, 3'd5, 6'd21, 5'd10);
        send_step(3'd7);
        send_step(3'd1);
        send_step(3'd0);
        send_step(3'd2);
        send_step(3'd3);
        send_step(3'd4);
        send_step(3'd5);
        send_step(3'd6);
        send_step(3'd0);
        send_step(3'd3);
        send_step(3'd6);
        send_step(3'd6);
        send_step(3'd7);
        send_step(3'd1);
        send_command(CMD_READ, 3'd2, 6'd1, 5'd1);

        // sizes below range clamp up, start falls outside: restart refused
        begin_phase(7'd0, 7'd1, 7'd63, 7'd31);
        send_command(CMD_RESTART, 3'd0, 6'd0, 5'd0);
        send_step(3'd3);
        send_command(CMD_READ, 3'd0, 6'd0, 5'd1);

        // sizes above range clamp down, start in the far corner
        begin_phase(7'd127, 7'd63, 7'd63, 7'd31);
        send_command(CMD_RESTART, 3'd7, 6'd63, 5'd31);
        send_step(3'd2);
        send_step(3'd0);
        send_step(3'd6);
        send_command(CMD_READ, 3'd0, 6'd63, 5'd31);

        // random phases, each a fresh setup and walk
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                rows = $urandom_range(3, 5);
                cols = $urandom_range(2, 4);
                srow = $urandom_range(0, rows - 1);
                scol = $urandom_range(0, cols - 1);
            end
            else if (kind < 78)
            begin
                rows = $urandom_range(6, 12);
                cols = $urandom_range(3, 8);
                srow = $urandom_range(0, rows - 1);
                scol = $urandom_range(0, cols - 1);
            end
            else if (kind < 88)
            begin
                rows = $urandom_range(0, 127);
                cols = $urandom_range(0, 63);
                srow = $urandom_range(0, 63);
                scol = $urandom_range(0, 31);
            end
            else if (kind < 96)
            begin
                rows = $urandom_range(3, 5);
                cols = $urandom_range(2, 4);
                srow = $urandom_range(0, 63);
                scol = $urandom_range(0, 31);
            end
            else
            begin
                rows = 64;
                cols = 32;
                srow = $urandom_range(0, 63);
                scol = $urandom_range(0, 31);
            end
            span_r = (rows < MIN_ROWS) ? MIN_ROWS : (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows;
            span_c = (cols < MIN_COLS) ? MIN_COLS : (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols;
            begin_phase(7'(rows), 7'(cols), 7'(srow), 7'(scol));
            send_command(CMD_RESTART, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                         5'($urandom_range(0, 31)));
            sent++;
            n = $urandom_range(30, 80);
            for (int k = 0; k < n; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_step(3'($urandom_range(0, 7)));
                else if (pick < 90)
                    send_command(CMD_READ, 3'($urandom_range(0, 7)),
                                 6'($urandom_range(0, span_r)), 5'($urandom_range(0, span_c)));
                else if (pick < 93)
                    send_command(CMD_READ, 3'($urandom_range(0, 7)),
                                 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
                else if (pick < 96)
                    send_command(CMD_SPARE, 3'($urandom_range(0, 7)),
                                 6'($urandom_range(0, span_r)), 5'($urandom_range(0, span_c)));
                else
                    send_command(CMD_RESTART, 3'($urandom_range(0, 7)),
                                 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
                sent++;
            end
        end

        // drain and let the last write-back settle
        s_tvalid <= 1'b0;
        while (reports_due != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && reports_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/grwc_pkg.sv
hdl/grwc_ram.sv
hdl/grid_random_walk_coverage.sv
verif/grid_walk_check.sv
verif/grid_random_walk_coverage_test.sv
